// ===== src/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the streaming SHA-256 unit.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned BlkW   = 16;   // words per block
  localparam int unsigned MsgW   = 61;   // byte counter width

  localparam logic [31:0] PadMark = 32'h8000_0000;

  typedef logic [3:0] widx_t;

  // top level sequencer
  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_ZERO, S_LEN_HI, S_LEN_LO, S_COMP, S_OUT
  } seq_state_t;

  // round engine
  typedef enum logic [1:0] {
    E_IDLE, E_LOAD, E_ROUND, E_FINAL
  } eng_state_t;

  typedef struct packed {
    logic start;   // compress the buffered block
    logic init;    // reload the initial hash value
  } eng_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;    // one-cycle pulse when the chaining state is updated
  } eng_sts_t;

  localparam logic [7:0][31:0] InitH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

  localparam logic [63:0][31:0] RoundK = {
    32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
    32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
    32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
    32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
    32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
    32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
    32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
    32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
    32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
    32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
    32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
    32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
    32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
    32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
    32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
    32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== src/sha_mem.sv =====
// ----------------------------------------------------------------------------
// sha_mem
// Block buffer: 16 x 32 single-write, single-read RAM, registered read data.
// ----------------------------------------------------------------------------
module sha_mem
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        wr_en,
  input  widx_t       wr_addr,
  input  logic [31:0] wr_data,
  input  widx_t       rd_addr,
  output logic [31:0] rd_data
);

  logic [31:0] mem [BlkW];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/sha_eng.sv =====
// ----------------------------------------------------------------------------
// sha_eng
// Compression engine: one round per cycle, message words streamed from the
// block buffer for rounds 0..15, then expanded in a 16-word schedule window.
// ----------------------------------------------------------------------------
module sha_eng
  import sha_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  eng_ctl_t         ctl,
  output eng_sts_t         sts,
  output widx_t            rd_addr,
  input  logic [31:0]      rd_data,
  output logic [7:0][31:0] hash
);

  eng_state_t       est_r, est_nxt;
  logic [5:0]       rnd_r, rnd_nxt;
  logic [7:0][31:0] v_r, v_nxt;
  logic [15:0][31:0] w_r, w_nxt;
  logic [7:0][31:0] h_r, h_nxt;

  logic [31:0] wr, x1, x2, ch, mj;

  // next state
  always_comb begin
    est_nxt = est_r;
    unique case (est_r)
      E_IDLE:  if (ctl.start) est_nxt = E_LOAD;
      E_LOAD:  est_nxt = E_ROUND;
      E_ROUND: if (rnd_r == 6'd63) est_nxt = E_FINAL;
      E_FINAL: est_nxt = E_IDLE;
      default: est_nxt = E_IDLE;
    endcase
  end

  // buffer read address runs one word ahead of the round
  always_comb begin
    rd_addr = '0;
    unique case (est_r)
      E_ROUND: rd_addr = rnd_r[3:0] + widx_t'(1);
      default: rd_addr = '0;
    endcase
  end

  // round datapath
  always_comb begin
    if (rnd_r < 6'd16) begin
      wr = rd_data;
    end else begin
      wr = ssig1(w_r[14]) + w_r[9] + ssig0(w_r[1]) + w_r[0];
    end
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    x1 = v_r[7] + bsig1(v_r[4]) + ch + RoundK[rnd_r] + wr;
    x2 = bsig0(v_r[0]) + mj;

    v_nxt   = v_r;
    w_nxt   = w_r;
    h_nxt   = h_r;
    rnd_nxt = rnd_r;
    unique case (est_r)
      E_IDLE: begin
        if (ctl.init) h_nxt = InitH;
      end
      E_LOAD: begin
        v_nxt   = h_r;
        rnd_nxt = '0;
      end
      E_ROUND: begin
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + x1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = x1 + x2;
        for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i+1];
        w_nxt[15] = wr;
        rnd_nxt   = rnd_r + 6'd1;
      end
      E_FINAL: begin
        for (int i = 0; i < 8; i++) h_nxt[i] = h_r[i] + v_r[i];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r <= E_IDLE;
      rnd_r <= '0;
      h_r   <= InitH;
    end else begin
      est_r <= est_nxt;
      rnd_r <= rnd_nxt;
      h_r   <= h_nxt;
    end
  end

  // working variables and schedule window
  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    w_r <= w_nxt;
  end

  assign sts.busy = (est_r != E_IDLE);
  assign sts.done = (est_r == E_FINAL);
  assign hash     = h_r;

endmodule

// ===== src/sha256_stream_hash_unit.sv =====
// A word that fills a block stalls input while that block is compressed;
// the last word adds padding writes, one or two compressions, then 8 outputs.
// Input waits for each block's compression, since the one-round-per-cycle
// engine shares the block buffer with the input.
// Reset: synchronous active-low rst_n; hash state returns to the initial value,
// counters clear. The same restart happens after the eighth digest transfer.
// ----------------------------------------------------------------------------
// sha256_stream_hash_unit
// Streaming SHA-256: packs bytes into the block buffer, pads, compresses and
// emits the eight digest words.
// ----------------------------------------------------------------------------
module sha256_stream_hash_unit
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic        out_digest_last
);

  seq_state_t  st_r, st_nxt, ret_r, ret_nxt;
  logic [5:0]  fill_r, fill_nxt;       // {word index, byte offset}
  logic [31:0] acc_r, acc_nxt;         // partial word, bytes packed high
  logic [MsgW-1:0] msg_r, msg_nxt;
  logic [2:0]  oidx_r, oidx_nxt;

  eng_ctl_t         ctl;
  eng_sts_t         sts;
  widx_t            rd_addr;
  logic [31:0]      rd_data;
  logic [7:0][31:0] hash;

  logic        wr_en;
  widx_t       wr_addr;
  logic [31:0] wr_data;

  widx_t       idx;
  logic [1:0]  off;
  logic [2:0]  cntc, tot;
  logic [31:0] masked, acc_eff, pad_word;
  logic [63:0] comb_w;
  logic        in_xfer, out_xfer, full_word, blk_end;

  assign idx      = fill_r[5:2];
  assign off      = fill_r[1:0];
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign blk_end  = (idx == widx_t'(BlkW - 1));

  // byte packing of an input word onto the current fill position
  always_comb begin
    cntc     = (in_byte_count > 3'd4) ? 3'd4 : in_byte_count;
    masked   = (cntc == 3'd4) ? in_data_word
             : (in_data_word & ~(32'hffff_ffff >> {cntc[1:0], 3'b000}));
    acc_eff  = (off == 2'd0) ? 32'd0 : acc_r;
    comb_w   = ({masked, 32'd0} >> {off, 3'b000}) | {acc_eff, 32'd0};
    tot      = {1'b0, off} + cntc;
    full_word = (tot >= 3'd4);
    pad_word = acc_eff | (PadMark >> {off, 3'b000});
  end

  // next state
  always_comb begin
    st_nxt  = st_r;
    ret_nxt = ret_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (full_word && blk_end) begin
            st_nxt  = S_COMP;
            ret_nxt = in_last_word ? S_PAD : S_IDLE;
          end else if (in_last_word) begin
            st_nxt = S_PAD;
          end
        end
      end
      S_PAD, S_ZERO: begin
        if (blk_end) begin
          st_nxt  = S_COMP;
          ret_nxt = S_ZERO;
        end else if (idx == widx_t'(13)) begin
          st_nxt = S_LEN_HI;
        end else begin
          st_nxt = S_ZERO;
        end
      end
      S_LEN_HI: st_nxt = S_LEN_LO;
      S_LEN_LO: begin
        st_nxt  = S_COMP;
        ret_nxt = S_OUT;
      end
      S_COMP: begin
        if (sts.done) begin
          st_nxt = (ret_r == S_ZERO && idx == widx_t'(14)) ? S_LEN_HI : ret_r;
        end
      end
      S_OUT: begin
        if (out_xfer && oidx_r == 3'd7) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    in_ready  = (st_r == S_IDLE);
    out_valid = (st_r == S_OUT);
    wr_en     = 1'b0;
    wr_addr   = idx;
    wr_data   = comb_w[63:32];
    ctl       = '0;
    fill_nxt  = fill_r;
    acc_nxt   = acc_r;
    msg_nxt   = msg_r;
    oidx_nxt  = oidx_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_xfer) begin
          msg_nxt = msg_r + MsgW'(cntc);
          if (full_word) begin
            wr_en    = 1'b1;
            acc_nxt  = comb_w[31:0];
            fill_nxt = {idx + widx_t'(1), 2'(tot - 3'd4)};
            ctl.start = blk_end;
          end else begin
            acc_nxt  = comb_w[63:32];
            fill_nxt = {idx, tot[1:0]};
          end
        end
      end
      S_PAD, S_ZERO: begin
        wr_en     = 1'b1;
        wr_data   = (st_r == S_PAD) ? pad_word : 32'd0;
        fill_nxt  = {idx + widx_t'(1), 2'd0};
        ctl.start = blk_end;
      end
      S_LEN_HI: begin
        wr_en    = 1'b1;
        wr_data  = msg_r[MsgW-1:MsgW-32];
        fill_nxt = {idx + widx_t'(1), 2'd0};
      end
      S_LEN_LO: begin
        wr_en     = 1'b1;
        wr_data   = {msg_r[MsgW-33:0], 3'b000};
        fill_nxt  = 6'd0;
        ctl.start = 1'b1;
      end
      S_OUT: begin
        if (out_xfer) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            ctl.init = 1'b1;
            msg_nxt  = '0;
            fill_nxt = '0;
          end
        end
      end
      default: ;
    endcase
    out_digest_word = hash[oidx_r];
    out_digest_last = (oidx_r == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      ret_r  <= S_IDLE;
      fill_r <= '0;
      msg_r  <= '0;
      oidx_r <= '0;
    end else begin
      st_r   <= st_nxt;
      ret_r  <= ret_nxt;
      fill_r <= fill_nxt;
      msg_r  <= msg_nxt;
      oidx_r <= oidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  sha_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sha_eng u_eng (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .sts     (sts),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .hash    (hash)
  );

`ifndef SYNTH
  // buffer is never written while the engine reads it
  a_no_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.busy |-> !wr_en) else $error("buffer write during compression");

  // compression only starts with the engine idle
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !sts.busy) else $error("start while engine busy");

  // input and output never both open
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input open during digest output");

  // after the final digest transfer the unit is back at the block start
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_digest_last) |=> (in_ready && fill_r == 6'd0 && msg_r == '0))
    else $error("no restart after digest");
`endif

endmodule
